// File: hdl/mlq_pkg.sv
// Shared constants, types and controller/datapath signal groups for the
// multilevel queue slot scheduler. No dependencies.
`default_nettype none

package mlq_pkg;

    localparam int NUM_PRIO    = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WIDTH    = 8;

    localparam int LVL_W  = $clog2(NUM_PRIO);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W = $clog2(NUM_PRIO + 1);
    localparam int STORE_DEPTH = NUM_PRIO * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    typedef logic [LVL_W-1:0]    lvl_t;
    typedef logic [PTR_W-1:0]    ptr_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [ID_WIDTH-1:0] id_t;

    typedef struct packed {
        logic load;
        logic enq;
        logic try_step;
        logic finish;
    } ctl_t;

    typedef struct packed {
        logic is_get;
        logic hit;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// File: hdl/mlq_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
`default_nettype none

module mlq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/mlq_datapath.sv
// Datapath: per-level FIFO pointers and counts, level/slot state, id store,
// result and output registers. Uses mlq_pkg and mlq_ram.
`default_nettype none

module mlq_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mlq_pkg::ctl_t ctl,
    output mlq_pkg::sts_t      sts,
    input  wire logic          command,
    input  wire logic [7:0]    proc_id,
    input  wire logic [7:0]    prio,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic               granted,
    output logic [7:0]         out_proc_id,
    output logic [2:0]         out_level,
    output logic               dropped
);

    mlq_pkg::ptr_t  head_reg  [mlq_pkg::NUM_PRIO];
    mlq_pkg::cnt_t  count_reg [mlq_pkg::NUM_PRIO];
    mlq_pkg::lvl_t  cur_reg, cur_next;
    mlq_pkg::slot_t slots_reg, slots_next;

    logic          is_get_reg;
    mlq_pkg::id_t  id_reg;
    mlq_pkg::lvl_t enq_lvl_reg;

    logic          res_granted_reg;
    mlq_pkg::lvl_t res_level_reg;
    logic          res_dropped_reg;
    logic          out_valid_reg;

    mlq_pkg::lvl_t  lvl_eff, lvl_after, sel_lvl;
    mlq_pkg::slot_t slots_eff;
    mlq_pkg::ptr_t  head_sel, head_inc;
    mlq_pkg::cnt_t  cnt_sel;
    logic [mlq_pkg::CNT_W:0] head_ext, wsum, wpos;
    mlq_pkg::ptr_t  ptr_sel;
    mlq_pkg::addr_t ram_addr;
    mlq_pkg::id_t   rd_data;
    logic           full, hit, wr_en, rd_en;

    function automatic mlq_pkg::lvl_t next_lvl(input mlq_pkg::lvl_t l);
        next_lvl = (l == mlq_pkg::lvl_t'(mlq_pkg::NUM_PRIO - 1)) ? '0 : l + 1'b1;
    endfunction

    function automatic mlq_pkg::slot_t lvl_slots(input mlq_pkg::lvl_t l);
        lvl_slots = mlq_pkg::slot_t'(mlq_pkg::NUM_PRIO) - mlq_pkg::slot_t'(l);
    endfunction

    always_comb
    begin
        if (slots_reg == '0)
        begin
            lvl_eff   = next_lvl(cur_reg);
            slots_eff = lvl_slots(next_lvl(cur_reg));
        end
        else
        begin
            lvl_eff   = cur_reg;
            slots_eff = slots_reg;
        end
        lvl_after = next_lvl(lvl_eff);
        sel_lvl   = ctl.try_step ? lvl_eff : enq_lvl_reg;
        head_sel  = head_reg[sel_lvl];
        cnt_sel   = count_reg[sel_lvl];
        full      = (cnt_sel == mlq_pkg::cnt_t'(mlq_pkg::QUEUE_DEPTH));
        hit       = (cnt_sel != '0);
        head_inc  = (head_sel == mlq_pkg::ptr_t'(mlq_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : head_sel + 1'b1;
        head_ext  = {{(mlq_pkg::CNT_W + 1 - mlq_pkg::PTR_W){1'b0}}, head_sel};
        wsum      = head_ext + {1'b0, cnt_sel};
        wpos      = (wsum >= (mlq_pkg::CNT_W + 1)'(mlq_pkg::QUEUE_DEPTH)) ?
                    wsum - (mlq_pkg::CNT_W + 1)'(mlq_pkg::QUEUE_DEPTH) : wsum;
        ptr_sel   = ctl.try_step ? head_sel : wpos[mlq_pkg::PTR_W-1:0];
        ram_addr  = mlq_pkg::addr_t'(mlq_pkg::addr_t'(sel_lvl)
                    * mlq_pkg::addr_t'(mlq_pkg::QUEUE_DEPTH)
                    + mlq_pkg::addr_t'(ptr_sel));
        wr_en     = ctl.enq && !full;
        rd_en     = ctl.try_step && hit;
        cur_next   = cur_reg;
        slots_next = slots_reg;
        if (ctl.try_step)
        begin
            if (hit)
            begin
                cur_next   = lvl_eff;
                slots_next = slots_eff - 1'b1;
            end
            else
            begin
                cur_next   = lvl_after;
                slots_next = lvl_slots(lvl_after);
            end
        end
    end

    mlq_ram #(
        .WIDTH (mlq_pkg::ID_WIDTH),
        .DEPTH (mlq_pkg::STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ram_addr),
        .wr_data (id_reg),
        .rd_en   (rd_en),
        .rd_addr (ram_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mlq_pkg::NUM_PRIO; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            cur_reg       <= '0;
            slots_reg     <= mlq_pkg::slot_t'(mlq_pkg::NUM_PRIO);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg   <= cur_next;
            slots_reg <= slots_next;
            if (wr_en)
            begin
                count_reg[sel_lvl] <= cnt_sel + 1'b1;
            end
            if (rd_en)
            begin
                head_reg[sel_lvl]  <= head_inc;
                count_reg[sel_lvl] <= cnt_sel - 1'b1;
            end
            if (ctl.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            is_get_reg      <= command;
            id_reg          <= mlq_pkg::id_t'(proc_id);
            enq_lvl_reg     <= (prio >= 8'(mlq_pkg::NUM_PRIO - 1)) ?
                               mlq_pkg::lvl_t'(mlq_pkg::NUM_PRIO - 1) :
                               mlq_pkg::lvl_t'(prio);
            res_granted_reg <= 1'b0;
            res_level_reg   <= '0;
            res_dropped_reg <= 1'b0;
        end
        if (ctl.enq)
        begin
            res_dropped_reg <= full;
        end
        if (rd_en)
        begin
            res_granted_reg <= 1'b1;
            res_level_reg   <= lvl_eff;
        end
        if (ctl.finish)
        begin
            granted     <= res_granted_reg;
            out_proc_id <= res_granted_reg ? 8'(rd_data) : 8'd0;
            out_level   <= 3'(res_level_reg);
            dropped     <= res_dropped_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sts.is_get   = is_get_reg;
    assign sts.hit      = hit;
    assign sts.out_free = !out_valid_reg || !out_stall;

endmodule

`default_nettype wire

// File: hdl/mlq_ctrl.sv
// Controller: sequences one transfer at a time through enqueue or the
// level scan, then hands the result to the output register. Uses mlq_pkg.
`default_nettype none

module mlq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output mlq_pkg::ctl_t      ctl,
    input  wire mlq_pkg::sts_t sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ENQ,
        S_SCAN,
        S_FIN
    } state_t;

    state_t        state_reg, state_next;
    mlq_pkg::lvl_t try_reg, try_next;

    always_comb
    begin
        state_next   = state_reg;
        try_next     = try_reg;
        ctl          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_ENQ;
                end
            end
            S_ENQ:
            begin
                if (sts.is_get)
                begin
                    try_next   = '0;
                    state_next = S_SCAN;
                end
                else
                begin
                    ctl.enq    = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_SCAN:
            begin
                ctl.try_step = 1'b1;
                if (sts.hit || try_reg == mlq_pkg::lvl_t'(mlq_pkg::NUM_PRIO - 1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    try_next = try_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            try_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            try_reg   <= try_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// File: hdl/mlq_slot_scheduler.sv
// Top level of the multilevel queue slot scheduler.
// Uses mlq_pkg, mlq_ctrl, mlq_datapath (which holds mlq_ram).
//
// channel  direction  handshake            payload
// in       to block   in_valid / in_stall  command, proc_id, prio
// out      from block out_valid / out_stall granted, out_proc_id, out_level, dropped
//
// One transfer in flight: an enqueue result is loaded after the load and enqueue states, in the finish state.
// A get goes from the enqueue state into the level scan, which tries one level per cycle, then to the finish state.
// The id store read is registered; it is read in the scan, before the result is loaded.
// The next transfer is taken the cycle after a result is loaded; a stalled result holds it.
// Reset clears pointers, counts, level 0 and its full slot count; no clearing pass.
`default_nettype none

module mlq_slot_scheduler (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       command,
    input  wire logic [7:0] proc_id,
    input  wire logic [7:0] prio,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            granted,
    output logic [7:0]      out_proc_id,
    output logic [2:0]      out_level,
    output logic            dropped
);

    mlq_pkg::ctl_t ctl;
    mlq_pkg::sts_t sts;

    mlq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .ctl      (ctl),
        .sts      (sts)
    );

    mlq_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .command     (command),
        .proc_id     (proc_id),
        .prio        (prio),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .granted     (granted),
        .out_proc_id (out_proc_id),
        .out_level   (out_level),
        .dropped     (dropped)
    );

endmodule

`default_nettype wire

// File: hdl/mlq_checker.sv
// Port-level checks for mlq_slot_scheduler, attached by bind.
// No dependencies.
`default_nettype none

module mlq_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       granted,
    input wire logic [7:0] out_proc_id,
    input wire logic [2:0] out_level,
    input wire logic       dropped
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transfer taken while busy");

    a_grant_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(granted && dropped))
        else $error("result both granted and dropped");

    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !granted |-> out_proc_id == 8'd0 && out_level == 3'd0)
        else $error("id or level set without a grant");

endmodule

bind mlq_slot_scheduler mlq_checker u_chk (.*);

`default_nettype wire

// File: verif/mlq_slot_scheduler_tb.sv
// Self-checking testbench for mlq_slot_scheduler: directed table then weighted random traffic,
// with bursty input, a patterned output stall and an in-bench predictor of the level queues.
// Depends on mlq_pkg and the mlq_slot_scheduler RTL.
`timescale 1ns / 1ps

module mlq_slot_scheduler_tb;

    typedef enum logic {CMD_ENQ = 1'b0, CMD_GET = 1'b1} cmd_e;

    typedef struct packed {
        logic       granted;
        logic [7:0] id;
        logic [2:0] level;
        logic       dropped;
    } sched_res_t;

    typedef struct packed {
        cmd_e       cmd;
        logic [7:0] id;
        logic [7:0] pr;
        logic [4:0] rep;
        logic       known;
        sched_res_t res;
    } dir_row_t;

    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    localparam sched_res_t RES_NONE    = '0;
    localparam sched_res_t RES_DROPPED = '{1'b0, 8'h00, 3'd0, 1'b1};

    // Empty get after reset, clamped enqueues, fill level 7 to the brim, one drop,
    // then gets that wrap the scan and exhaust the single slot of level 7.
    localparam dir_row_t DIR_TABLE [0:7] = '{
        '{CMD_GET, 8'h00, 8'h00, 5'd1,  1'b1, RES_NONE},
        '{CMD_ENQ, 8'hFF, 8'hFF, 5'd1,  1'b1, RES_NONE},
        '{CMD_ENQ, 8'h00, 8'h08, 5'd1,  1'b1, RES_NONE},
        '{CMD_ENQ, 8'h5A, 8'h07, 5'd14, 1'b1, RES_NONE},
        '{CMD_ENQ, 8'hA5, 8'h80, 5'd1,  1'b1, RES_DROPPED},
        '{CMD_ENQ, 8'h3C, 8'h00, 5'd1,  1'b1, RES_NONE},
        '{CMD_ENQ, 8'hC3, 8'h01, 5'd1,  1'b1, RES_NONE},
        '{CMD_GET, 8'h00, 8'h00, 5'd4,  1'b0, RES_NONE}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       command = 1'b0;
    logic [7:0] proc_id = 8'h00;
    logic [7:0] prio = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       granted;
    logic [7:0] out_proc_id;
    logic [2:0] out_level;
    logic       dropped;

    logic       tag_known = 1'b0;
    sched_res_t tag_res = '0;

    mlq_pkg::id_t   lvl_ids  [mlq_pkg::NUM_PRIO][mlq_pkg::QUEUE_DEPTH];
    mlq_pkg::ptr_t  lvl_head [mlq_pkg::NUM_PRIO] = '{default: '0};
    mlq_pkg::cnt_t  lvl_fill [mlq_pkg::NUM_PRIO] = '{default: '0};
    mlq_pkg::lvl_t  serve_lvl = '0;
    mlq_pkg::slot_t serve_slots = mlq_pkg::slot_t'(mlq_pkg::NUM_PRIO);

    sched_res_t replies_due [$];

    int cycles = 0;
    int mismatches = 0;
    int burst_left = 0;
    int n_enq = 0;
    int n_drop = 0;
    int n_get = 0;
    int n_grant = 0;

    int       stall_hold = 0;
    int       stall_mode = 0;
    bit [3:0] stall_phase = '0;

    mlq_slot_scheduler uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .proc_id    (proc_id),
        .prio       (prio),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .granted    (granted),
        .out_proc_id(out_proc_id),
        .out_level  (out_level),
        .dropped    (dropped)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void step_level();
        serve_lvl   = mlq_pkg::lvl_t'((int'(serve_lvl) + 1) % mlq_pkg::NUM_PRIO);
        serve_slots = mlq_pkg::slot_t'(mlq_pkg::NUM_PRIO - int'(serve_lvl));
    endfunction

    function automatic sched_res_t next_reply(input cmd_e c, input logic [7:0] id,
                                              input logic [7:0] pr);
        sched_res_t    r;
        mlq_pkg::lvl_t lvl;
        bit            found;
        r = '0;
        found = 1'b0;
        if (c == CMD_ENQ)
        begin
            lvl = (pr >= mlq_pkg::NUM_PRIO) ? mlq_pkg::lvl_t'(mlq_pkg::NUM_PRIO - 1)
                                            : mlq_pkg::lvl_t'(pr);
            if (lvl_fill[lvl] >= mlq_pkg::QUEUE_DEPTH)
                r.dropped = 1'b1;
            else
            begin
                lvl_ids[lvl][(int'(lvl_head[lvl]) + int'(lvl_fill[lvl]))
                             % mlq_pkg::QUEUE_DEPTH] = mlq_pkg::id_t'(id);
                lvl_fill[lvl] = lvl_fill[lvl] + 1'b1;
            end
        end
        else
        begin
            for (int t = 0; t < mlq_pkg::NUM_PRIO && !found; t++)
            begin
                if (serve_slots == 0)
                    step_level();
                if (lvl_fill[serve_lvl] == 0)
                    step_level();
                else
                begin
                    r.granted = 1'b1;
                    r.id      = 8'(lvl_ids[serve_lvl][lvl_head[serve_lvl]]);
                    r.level   = 3'(serve_lvl);
                    lvl_head[serve_lvl] = mlq_pkg::ptr_t'((int'(lvl_head[serve_lvl]) + 1)
                                                          % mlq_pkg::QUEUE_DEPTH);
                    lvl_fill[serve_lvl] = lvl_fill[serve_lvl] - 1'b1;
                    serve_slots = serve_slots - 1'b1;
                    found = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Call just after a rising edge; returns just after the edge that takes the transfer.
    task automatic send(input cmd_e c, input logic [7:0] id, input logic [7:0] pr,
                        input logic known, input sched_res_t res);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid  <= 1'b1;
        command   <= c;
        proc_id   <= id;
        prio      <= pr;
        tag_known <= known;
        tag_res   <= res;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycles, replies_due.size());
            $display("mlq_slot_scheduler_tb NOT OK");
            $finish;
        end
    end

    // Receiver stall: modes of none, light, heavy and a periodic 11-of-16 pattern.
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1'b1;
        if (stall_hold == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_hold <= $urandom_range(32, 400);
        end
        else
            stall_hold <= stall_hold - 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 7) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (stall_phase < 4'd11);
        endcase
    end

    always @(posedge clk)
    begin
        sched_res_t got;
        sched_res_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                want = next_reply(cmd_e'(command), proc_id, prio);
                replies_due.push_back(tag_known ? tag_res : want);
                if (command == CMD_ENQ)
                    n_enq++;
                else
                    n_get++;
            end
            if (out_valid && !out_stall)
            begin
                got = {granted, out_proc_id, out_level, dropped};
                if (got.granted)
                    n_grant++;
                if (got.dropped)
                    n_drop++;
                if (replies_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected transfer granted=%b id=%h level=%0d dropped=%b",
                                 $realtime, got.granted, got.id, got.level, got.dropped);
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("%0t: mismatch exp granted=%b id=%h level=%0d dropped=%b",
                                     $realtime, want.granted, want.id, want.level,
                                     want.dropped);
                            $display("    got granted=%b id=%h level=%0d dropped=%b",
                                     got.granted, got.id, got.level, got.dropped);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        int   sent;
        int   phase_len;
        int   enq_pct;
        int   prio_mode;
        int   focus;
        cmd_e c;
        logic [7:0] pr;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(DIR_TABLE); i++)
            repeat (DIR_TABLE[i].rep)
                send(DIR_TABLE[i].cmd, DIR_TABLE[i].id, DIR_TABLE[i].pr,
                     DIR_TABLE[i].known, DIR_TABLE[i].res);

        // Phases vary the enqueue share and how tightly priorities cluster,
        // so queues both run dry and fill to overflow.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(60, 200);
            case ($urandom_range(0, 3))
                0:       enq_pct = 25;
                1:       enq_pct = 50;
                2:       enq_pct = 75;
                default: enq_pct = 95;
            endcase
            prio_mode = $urandom_range(0, 2);
            focus = $urandom_range(0, mlq_pkg::NUM_PRIO - 1);
            repeat (phase_len)
            begin
                c = ($urandom_range(1, 100) <= enq_pct) ? CMD_ENQ : CMD_GET;
                case (prio_mode)
                    0:       pr = 8'($urandom_range(0, mlq_pkg::NUM_PRIO - 1));
                    1:       pr = 8'($urandom_range(0, 255));
                    default: pr = (focus == mlq_pkg::NUM_PRIO - 1
                                   && $urandom_range(0, 1) == 1) ?
                                  8'($urandom_range(mlq_pkg::NUM_PRIO, 255)) : 8'(focus);
                endcase
                send(c, 8'($urandom_range(0, 255)), pr, 1'b0, RES_NONE);
                sent++;
            end
        end
        in_valid <= 1'b0;

        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (4 * mlq_pkg::NUM_PRIO) @(posedge clk);

        $display("run covered %0d enqueues (%0d dropped on a full level) and %0d gets (%0d empty)",
                 n_enq, n_drop, n_get, n_get - n_grant);
        $display("%0d mismatches over %0d cycles", mismatches, cycles);
        if (mismatches == 0)
            $display("mlq_slot_scheduler_tb OK");
        else
            $display("mlq_slot_scheduler_tb NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
hdl/mlq_pkg.sv
hdl/mlq_ram.sv
hdl/mlq_datapath.sv
hdl/mlq_ctrl.sv
hdl/mlq_slot_scheduler.sv
hdl/mlq_checker.sv
verif/mlq_slot_scheduler_tb.sv
